### src/ltt_pkg.sv
package ltt_pkg;

    localparam int LINE_BITS   = 20;
    localparam int COLUMN_BITS = 16;
    localparam int BRACKET_MAX = 15;
    localparam int BR_BITS     = $clog2(BRACKET_MAX + 1);
    localparam int MAX_RES     = 6;
    localparam int RES_BITS    = $clog2(MAX_RES + 1);
    localparam int IDX_BITS    = $clog2(MAX_RES);
    localparam int Q_DEPTH     = 4;
    localparam int QP_BITS     = $clog2(Q_DEPTH);

    localparam logic [2:0] K_END    = 3'd0;
    localparam logic [2:0] K_SINGLE = 3'd1;
    localparam logic [2:0] K_STRING = 3'd2;
    localparam logic [2:0] K_NUMBER = 3'd3;
    localparam logic [2:0] K_KEYWD  = 3'd4;
    localparam logic [2:0] K_OPENC  = 3'd5;
    localparam logic [2:0] K_BADSTR = 3'd6;

    localparam logic [7:0] C_NL    = 8'h0a;
    localparam logic [7:0] C_UNDER = 8'h5f;
    localparam logic [7:0] C_LK    = 8'h6b;
    localparam logic [7:0] C_UK    = 8'h4b;
    localparam logic [7:0] C_LE    = 8'h65;
    localparam logic [7:0] C_UE    = 8'h45;
    localparam logic [7:0] C_THREE = 8'h33;
    localparam logic [7:0] C_QUOTE = 8'h22;
    localparam logic [7:0] C_BSL   = 8'h5c;
    localparam logic [7:0] C_SLASH = 8'h2f;
    localparam logic [7:0] C_STAR  = 8'h2a;
    localparam logic [7:0] C_LBR   = 8'h5b;
    localparam logic [7:0] C_RBR   = 8'h5d;
    localparam logic [7:0] C_DOT   = 8'h2e;
    localparam logic [7:0] C_PLUS  = 8'h2b;
    localparam logic [7:0] C_MINUS = 8'h2d;
    localparam logic [7:0] C_COLON = 8'h3a;

    typedef enum logic [15:0] {
        S_IDLE  = 16'h0001,
        S_BSL   = 16'h0002,
        S_SLASH = 16'h0004,
        S_LCOM  = 16'h0008,
        S_BCOM  = 16'h0010,
        S_STR   = 16'h0020,
        S_SESC  = 16'h0040,
        S_DOT   = 16'h0080,
        S_SIGN  = 16'h0100,
        S_SDOT  = 16'h0200,
        S_INT   = 16'h0400,
        S_FRAC  = 16'h0800,
        S_ESGN  = 16'h1000,
        S_EXP   = 16'h2000,
        S_ID    = 16'h4000,
        S_HALT  = 16'h8000
    } t_mode;

    typedef struct packed {
        logic [2:0]             kind;
        logic [7:0]             ch;
        logic                   valid;
        logic                   last;
        logic [LINE_BITS-1:0]   line;
        logic [COLUMN_BITS-1:0] column;
    } t_res;

    typedef struct packed {
        logic [RES_BITS-1:0] cnt;
        t_res [MAX_RES-1:0]  res;
    } t_group;

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == 8'h20 || (c >= 8'h09 && c <= 8'h0d);
    endfunction

    function automatic t_res mk(input logic [2:0] kind, input logic [7:0] ch,
                                input logic valid, input logic last,
                                input logic [LINE_BITS-1:0] ln,
                                input logic [COLUMN_BITS-1:0] cl);
        t_res r;
        r.kind   = kind;
        r.ch     = ch;
        r.valid  = valid;
        r.last   = last;
        r.line   = ln;
        r.column = cl;
        return r;
    endfunction

endpackage

### src/ltt_front.sv
module ltt_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_take,
    input  logic [7:0]          i_byte,
    input  logic                i_eoi,
    output logic                o_push,
    output ltt_pkg::t_group     o_group
);

    ltt_pkg::t_mode                      r_mode, n_mode;
    logic [ltt_pkg::LINE_BITS-1:0]       r_line, n_line, r_tl, n_tl;
    logic [ltt_pkg::COLUMN_BITS-1:0]     r_col, n_col, r_tc, n_tc;
    logic [7:0]                          r_look, n_look, r_sign, n_sign;
    logic [ltt_pkg::BR_BITS-1:0]         r_br, n_br;
    logic                                r_star, n_star;

    ltt_pkg::t_res [ltt_pkg::MAX_RES-1:0] res;
    logic [ltt_pkg::RES_BITS-1:0]         cnt;

    always_comb begin
        logic start;
        logic ntail;
        logic [7:0] b;
        n_mode = r_mode; n_line = r_line; n_col = r_col; n_tl = r_tl; n_tc = r_tc;
        n_look = r_look; n_sign = r_sign; n_br = r_br; n_star = r_star;
        res = '0;
        cnt = '0;
        start = 1'b0;
        ntail = 1'b0;
        b = i_byte;
        if (i_take && r_mode != ltt_pkg::S_HALT) begin
            if (i_eoi) begin
                case (r_mode)
                    ltt_pkg::S_BSL, ltt_pkg::S_SLASH, ltt_pkg::S_DOT: begin
                        res[cnt[ltt_pkg::IDX_BITS-1:0]] =
                            ltt_pkg::mk(ltt_pkg::K_SINGLE, r_look, 1'b1, 1'b1, r_tl, r_tc);
                        cnt = cnt + 1'b1;
                    end
                    ltt_pkg::S_SIGN, ltt_pkg::S_SDOT: begin
                        res[cnt[ltt_pkg::IDX_BITS-1:0]] =
                            ltt_pkg::mk(ltt_pkg::K_SINGLE, r_sign, 1'b1, 1'b1, r_tl, r_tc);
                        cnt = cnt + 1'b1;
                    end
                    ltt_pkg::S_INT, ltt_pkg::S_FRAC, ltt_pkg::S_ESGN, ltt_pkg::S_EXP: begin
                        res[cnt[ltt_pkg::IDX_BITS-1:0]] =
                            ltt_pkg::mk(ltt_pkg::K_NUMBER, 8'd0, 1'b0, 1'b1, r_tl, r_tc);
                        cnt = cnt + 1'b1;
                    end
                    ltt_pkg::S_ID: begin
                        res[cnt[ltt_pkg::IDX_BITS-1:0]] =
                            ltt_pkg::mk(ltt_pkg::K_KEYWD, 8'd0, 1'b0, 1'b1, r_tl, r_tc);
                        cnt = cnt + 1'b1;
                    end
                    ltt_pkg::S_STR, ltt_pkg::S_SESC: begin
                        res[cnt[ltt_pkg::IDX_BITS-1:0]] =
                            ltt_pkg::mk(ltt_pkg::K_BADSTR, 8'd0, 1'b0, 1'b1, r_tl, r_tc);
                        cnt = cnt + 1'b1;
                    end
                    ltt_pkg::S_BCOM: begin
                        res[cnt[ltt_pkg::IDX_BITS-1:0]] =
                            ltt_pkg::mk(ltt_pkg::K_OPENC, 8'd0, 1'b0, 1'b1, r_tl, r_tc);
                        cnt = cnt + 1'b1;
                    end
                    default: ;
                endcase
                if (r_mode != ltt_pkg::S_STR && r_mode != ltt_pkg::S_SESC &&
                    r_mode != ltt_pkg::S_BCOM) begin
                    res[cnt[ltt_pkg::IDX_BITS-1:0]] =
                        ltt_pkg::mk(ltt_pkg::K_END, 8'd0, 1'b0, 1'b1, '0, '0);
                    cnt = cnt + 1'b1;
                end
                n_mode = ltt_pkg::S_HALT;
            end else begin
                if (b == ltt_pkg::C_NL) begin
                    if (r_line != '1) n_line = r_line + 1'b1;
                    n_col = {{(ltt_pkg::COLUMN_BITS-1){1'b0}}, 1'b1};
                end else if (r_col != '1) begin
                    n_col = r_col + 1'b1;
                end
                case (r_mode)
                    ltt_pkg::S_IDLE: start = 1'b1;
                    ltt_pkg::S_BSL, ltt_pkg::S_SLASH: begin
                        if (r_mode == ltt_pkg::S_BSL && b == ltt_pkg::C_NL) begin
                            n_mode = ltt_pkg::S_IDLE;
                        end else if (r_mode == ltt_pkg::S_SLASH && b == ltt_pkg::C_SLASH) begin
                            n_mode = ltt_pkg::S_LCOM;
                        end else if (r_mode == ltt_pkg::S_SLASH && b == ltt_pkg::C_STAR) begin
                            n_star = 1'b0;
                            n_mode = ltt_pkg::S_BCOM;
                        end else begin
                            res[cnt[ltt_pkg::IDX_BITS-1:0]] =
                                ltt_pkg::mk(ltt_pkg::K_SINGLE, r_look, 1'b1, 1'b1, r_tl, r_tc);
                            cnt = cnt + 1'b1;
                            n_mode = ltt_pkg::S_IDLE;
                            start = 1'b1;
                        end
                    end
                    ltt_pkg::S_LCOM: if (b == ltt_pkg::C_NL) n_mode = ltt_pkg::S_IDLE;
                    ltt_pkg::S_BCOM: begin
                        if (b == ltt_pkg::C_SLASH && r_star) n_mode = ltt_pkg::S_IDLE;
                        n_star = (b == ltt_pkg::C_STAR);
                    end
                    ltt_pkg::S_STR: begin
                        if (b == ltt_pkg::C_QUOTE) begin
                            res[cnt[ltt_pkg::IDX_BITS-1:0]] =
                                ltt_pkg::mk(ltt_pkg::K_STRING, 8'd0, 1'b0, 1'b1, r_tl, r_tc);
                            cnt = cnt + 1'b1;
                            n_mode = ltt_pkg::S_IDLE;
                        end else if (b == ltt_pkg::C_BSL) begin
                            n_mode = ltt_pkg::S_SESC;
                        end else if (b == ltt_pkg::C_NL) begin
                            res[cnt[ltt_pkg::IDX_BITS-1:0]] =
                                ltt_pkg::mk(ltt_pkg::K_BADSTR, 8'd0, 1'b0, 1'b1, r_tl, r_tc);
                            cnt = cnt + 1'b1;
                            n_mode = ltt_pkg::S_HALT;
                        end else begin
                            res[cnt[ltt_pkg::IDX_BITS-1:0]] =
                                ltt_pkg::mk(ltt_pkg::K_STRING, b, 1'b1, 1'b0, r_tl, r_tc);
                            cnt = cnt + 1'b1;
                        end
                    end
                    ltt_pkg::S_SESC: begin
                        if (b != ltt_pkg::C_NL) begin
                            res[cnt[ltt_pkg::IDX_BITS-1:0]] =
                                ltt_pkg::mk(ltt_pkg::K_STRING, b, 1'b1, 1'b0, r_tl, r_tc);
                            cnt = cnt + 1'b1;
                        end
                        n_mode = ltt_pkg::S_STR;
                    end
                    ltt_pkg::S_DOT: begin
                        if (ltt_pkg::is_digit(b)) begin
                            res[0] = ltt_pkg::mk(ltt_pkg::K_NUMBER, ltt_pkg::C_DOT, 1'b1, 1'b0,
                                                 r_tl, r_tc);
                            res[1] = ltt_pkg::mk(ltt_pkg::K_NUMBER, b, 1'b1, 1'b0, r_tl, r_tc);
                            cnt = 3'd2;
                            n_mode = ltt_pkg::S_FRAC;
                        end else begin
                            res[0] = ltt_pkg::mk(ltt_pkg::K_SINGLE, ltt_pkg::C_DOT, 1'b1, 1'b1,
                                                 r_tl, r_tc);
                            cnt = 3'd1;
                            n_mode = ltt_pkg::S_IDLE;
                            start = 1'b1;
                        end
                    end
                    ltt_pkg::S_SIGN: begin
                        if (ltt_pkg::is_digit(b)) begin
                            res[0] = ltt_pkg::mk(ltt_pkg::K_NUMBER, r_sign, 1'b1, 1'b0, r_tl, r_tc);
                            res[1] = ltt_pkg::mk(ltt_pkg::K_NUMBER, b, 1'b1, 1'b0, r_tl, r_tc);
                            cnt = 3'd2;
                            n_mode = ltt_pkg::S_INT;
                        end else if (b == ltt_pkg::C_DOT || b == ltt_pkg::C_UNDER) begin
                            n_mode = ltt_pkg::S_SDOT;
                        end else begin
                            res[0] = ltt_pkg::mk(ltt_pkg::K_SINGLE, r_sign, 1'b1, 1'b1, r_tl, r_tc);
                            cnt = 3'd1;
                            n_mode = ltt_pkg::S_IDLE;
                            start = 1'b1;
                        end
                    end
                    ltt_pkg::S_SDOT: begin
                        if (ltt_pkg::is_digit(b)) begin
                            res[0] = ltt_pkg::mk(ltt_pkg::K_NUMBER, r_sign, 1'b1, 1'b0, r_tl, r_tc);
                            res[1] = ltt_pkg::mk(ltt_pkg::K_NUMBER, ltt_pkg::C_DOT, 1'b1, 1'b0,
                                                 r_tl, r_tc);
                            res[2] = ltt_pkg::mk(ltt_pkg::K_NUMBER, b, 1'b1, 1'b0, r_tl, r_tc);
                            cnt = 3'd3;
                            n_mode = ltt_pkg::S_FRAC;
                        end else if (b == ltt_pkg::C_LK || b == ltt_pkg::C_UK ||
                                     b == ltt_pkg::C_LE || b == ltt_pkg::C_UE) begin
                            res[0] = ltt_pkg::mk(ltt_pkg::K_NUMBER, r_sign, 1'b1, 1'b0, r_tl, r_tc);
                            res[1] = ltt_pkg::mk(ltt_pkg::K_NUMBER, ltt_pkg::C_DOT, 1'b1, 1'b0,
                                                 r_tl, r_tc);
                            cnt = 3'd2;
                            ntail = 1'b1;
                        end else begin
                            res[0] = ltt_pkg::mk(ltt_pkg::K_SINGLE, r_sign, 1'b1, 1'b1, r_tl, r_tc);
                            cnt = 3'd1;
                            n_mode = ltt_pkg::S_IDLE;
                            start = 1'b1;
                        end
                        n_sign = 8'd0;
                    end
                    ltt_pkg::S_INT: begin
                        if (ltt_pkg::is_digit(b)) begin
                            res[0] = ltt_pkg::mk(ltt_pkg::K_NUMBER, b, 1'b1, 1'b0, r_tl, r_tc);
                            cnt = 3'd1;
                        end else if (b == ltt_pkg::C_DOT || b == ltt_pkg::C_UNDER) begin
                            res[0] = ltt_pkg::mk(ltt_pkg::K_NUMBER, ltt_pkg::C_DOT, 1'b1, 1'b0,
                                                 r_tl, r_tc);
                            cnt = 3'd1;
                            n_mode = ltt_pkg::S_FRAC;
                        end else begin
                            ntail = 1'b1;
                        end
                    end
                    ltt_pkg::S_FRAC: begin
                        if (ltt_pkg::is_digit(b)) begin
                            res[0] = ltt_pkg::mk(ltt_pkg::K_NUMBER, b, 1'b1, 1'b0, r_tl, r_tc);
                            cnt = 3'd1;
                        end else begin
                            ntail = 1'b1;
                        end
                    end
                    ltt_pkg::S_ESGN, ltt_pkg::S_EXP: begin
                        if (ltt_pkg::is_digit(b) || (r_mode == ltt_pkg::S_ESGN &&
                            (b == ltt_pkg::C_PLUS || b == ltt_pkg::C_MINUS))) begin
                            res[0] = ltt_pkg::mk(ltt_pkg::K_NUMBER, b, 1'b1, 1'b0, r_tl, r_tc);
                            cnt = 3'd1;
                            n_mode = ltt_pkg::S_EXP;
                        end else begin
                            res[0] = ltt_pkg::mk(ltt_pkg::K_NUMBER, 8'd0, 1'b0, 1'b1, r_tl, r_tc);
                            cnt = 3'd1;
                            n_mode = ltt_pkg::S_IDLE;
                            start = 1'b1;
                        end
                    end
                    ltt_pkg::S_ID: begin
                        if (b == ltt_pkg::C_LBR || b == ltt_pkg::C_RBR ||
                            ltt_pkg::is_alpha(b) || ltt_pkg::is_digit(b) ||
                            b == ltt_pkg::C_UNDER || b == ltt_pkg::C_DOT ||
                            b == ltt_pkg::C_MINUS || (b == ltt_pkg::C_COLON && r_br != '0)) begin
                            if (b == ltt_pkg::C_LBR &&
                                r_br < ltt_pkg::BR_BITS'(ltt_pkg::BRACKET_MAX)) n_br = r_br + 1'b1;
                            if (b == ltt_pkg::C_RBR && r_br != '0) n_br = r_br - 1'b1;
                            res[0] = ltt_pkg::mk(ltt_pkg::K_KEYWD, b, 1'b1, 1'b0, r_tl, r_tc);
                            cnt = 3'd1;
                        end else begin
                            res[0] = ltt_pkg::mk(ltt_pkg::K_KEYWD, 8'd0, 1'b0, 1'b1, r_tl, r_tc);
                            cnt = 3'd1;
                            n_mode = ltt_pkg::S_IDLE;
                            start = 1'b1;
                        end
                    end
                    default: ;
                endcase
                // number suffix or end after the mantissa
                if (ntail) begin
                    if (b == ltt_pkg::C_LK || b == ltt_pkg::C_UK) begin
                        res[cnt[ltt_pkg::IDX_BITS-1:0]] =
                            ltt_pkg::mk(ltt_pkg::K_NUMBER, ltt_pkg::C_LE, 1'b1, 1'b0, r_tl, r_tc);
                        cnt = cnt + 1'b1;
                        res[cnt[ltt_pkg::IDX_BITS-1:0]] =
                            ltt_pkg::mk(ltt_pkg::K_NUMBER, ltt_pkg::C_THREE, 1'b1, 1'b0,
                                        r_tl, r_tc);
                        cnt = cnt + 1'b1;
                        res[cnt[ltt_pkg::IDX_BITS-1:0]] =
                            ltt_pkg::mk(ltt_pkg::K_NUMBER, 8'd0, 1'b0, 1'b1, r_tl, r_tc);
                        cnt = cnt + 1'b1;
                        n_mode = ltt_pkg::S_IDLE;
                    end else if (b == ltt_pkg::C_LE || b == ltt_pkg::C_UE) begin
                        res[cnt[ltt_pkg::IDX_BITS-1:0]] =
                            ltt_pkg::mk(ltt_pkg::K_NUMBER, b, 1'b1, 1'b0, r_tl, r_tc);
                        cnt = cnt + 1'b1;
                        n_mode = ltt_pkg::S_ESGN;
                    end else begin
                        res[cnt[ltt_pkg::IDX_BITS-1:0]] =
                            ltt_pkg::mk(ltt_pkg::K_NUMBER, 8'd0, 1'b0, 1'b1, r_tl, r_tc);
                        cnt = cnt + 1'b1;
                        n_mode = ltt_pkg::S_IDLE;
                        start = 1'b1;
                    end
                end
                // open a new token from idle, or rescan the byte after a close
                if (start) begin
                    if (r_mode == ltt_pkg::S_BSL || r_mode == ltt_pkg::S_SLASH ||
                        r_mode == ltt_pkg::S_DOT) n_look = 8'd0;
                    if (r_mode == ltt_pkg::S_SIGN) n_sign = 8'd0;
                    if (!ltt_pkg::is_space(b)) begin
                        n_tl = r_line;
                        n_tc = r_col;
                        if (b == ltt_pkg::C_BSL) begin
                            n_look = b;
                            n_mode = ltt_pkg::S_BSL;
                        end else if (b == ltt_pkg::C_SLASH) begin
                            n_look = b;
                            n_mode = ltt_pkg::S_SLASH;
                        end else if (b == ltt_pkg::C_QUOTE) begin
                            n_mode = ltt_pkg::S_STR;
                        end else if (ltt_pkg::is_digit(b)) begin
                            res[cnt[ltt_pkg::IDX_BITS-1:0]] =
                                ltt_pkg::mk(ltt_pkg::K_NUMBER, b, 1'b1, 1'b0, r_line, r_col);
                            cnt = cnt + 1'b1;
                            n_mode = ltt_pkg::S_INT;
                        end else if (b == ltt_pkg::C_DOT) begin
                            n_look = b;
                            n_mode = ltt_pkg::S_DOT;
                        end else if (b == ltt_pkg::C_PLUS || b == ltt_pkg::C_MINUS) begin
                            n_sign = b;
                            n_mode = ltt_pkg::S_SIGN;
                        end else if (ltt_pkg::is_alpha(b) || b == ltt_pkg::C_UNDER) begin
                            n_br = '0;
                            res[cnt[ltt_pkg::IDX_BITS-1:0]] =
                                ltt_pkg::mk(ltt_pkg::K_KEYWD, b, 1'b1, 1'b0, r_line, r_col);
                            cnt = cnt + 1'b1;
                            n_mode = ltt_pkg::S_ID;
                        end else begin
                            res[cnt[ltt_pkg::IDX_BITS-1:0]] =
                                ltt_pkg::mk(ltt_pkg::K_SINGLE, b, 1'b1, 1'b1, r_line, r_col);
                            cnt = cnt + 1'b1;
                        end
                    end
                end else if (r_mode == ltt_pkg::S_BSL || r_mode == ltt_pkg::S_SLASH ||
                             r_mode == ltt_pkg::S_DOT) begin
                    n_look = 8'd0;
                end
            end
        end
    end

    assign o_push        = cnt != '0;
    assign o_group.cnt   = cnt;
    assign o_group.res   = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= ltt_pkg::S_IDLE;
            r_line <= {{(ltt_pkg::LINE_BITS-1){1'b0}}, 1'b1};
            r_col  <= {{(ltt_pkg::COLUMN_BITS-1){1'b0}}, 1'b1};
            r_tl   <= '0;
            r_tc   <= '0;
            r_look <= '0;
            r_sign <= '0;
            r_br   <= '0;
            r_star <= 1'b0;
        end else begin
            r_mode <= n_mode;
            r_line <= n_line;
            r_col  <= n_col;
            r_tl   <= n_tl;
            r_tc   <= n_tc;
            r_look <= n_look;
            r_sign <= n_sign;
            r_br   <= n_br;
            r_star <= n_star;
        end
    end

    a_halt_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode == ltt_pkg::S_HALT |=> r_mode == ltt_pkg::S_HALT)
        else $error("lexer left halt");
    a_halt_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode == ltt_pkg::S_HALT |-> !o_push)
        else $error("halted lexer produced a result");
    a_counters_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_line != '0 && r_col != '0)
        else $error("position counter reached zero");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cnt <= ltt_pkg::RES_BITS'(ltt_pkg::MAX_RES))
        else $error("too many results for one byte");

endmodule

### src/ltt_back.sv
module ltt_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  ltt_pkg::t_group     i_group,
    output logic                o_full,
    output logic                o_valid,
    input  logic                i_ready,
    output ltt_pkg::t_res       o_res
);

    ltt_pkg::t_group                 r_q [ltt_pkg::Q_DEPTH];
    logic [ltt_pkg::QP_BITS-1:0]     r_wp, r_rp;
    logic [ltt_pkg::QP_BITS:0]       r_cnt;
    logic [ltt_pkg::IDX_BITS-1:0]    r_idx;
    ltt_pkg::t_group                 head;
    logic                            step, pop;

    assign head    = r_q[r_rp];
    assign o_full  = r_cnt == (ltt_pkg::QP_BITS+1)'(ltt_pkg::Q_DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_res   = head.res[r_idx];
    assign step    = o_valid && i_ready;
    // drop the group once its last result has gone
    assign pop     = step && (ltt_pkg::RES_BITS'(r_idx) == head.cnt - 1'b1);

    always_ff @(posedge i_clk) begin
        if (i_push) r_q[r_wp] <= i_group;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
            r_idx <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (pop) begin
                r_rp  <= r_rp + 1'b1;
                r_idx <= '0;
            end else if (step) begin
                r_idx <= r_idx + 1'b1;
            end
            r_cnt <= r_cnt + (ltt_pkg::QP_BITS+1)'(i_push) - (ltt_pkg::QP_BITS+1)'(pop);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("push into full queue");
    a_head_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> head.cnt != '0 && ltt_pkg::RES_BITS'(r_idx) < head.cnt)
        else $error("result index outside its group");
    a_last_pops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step && o_res.last && o_res.kind == ltt_pkg::K_END |-> pop)
        else $error("end marker not last of its group");

endmodule

### src/liberty_text_tokenizer.sv
// Each accepted byte's results enter a four-group result queue as one group and are
// offered from its head in order. Throughput: one byte per cycle while each byte
// yields at most one result and the output is ready; a byte with n results holds
// the output for n handshakes, and the queue absorbs such bursts before input stalls.
// Reset (synchronous, active low): idle, line and column 1, queue empty.
module liberty_text_tokenizer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_text_byte,
    input  logic        i_end_of_input,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_token_kind,
    output logic [7:0]  o_text_char,
    output logic        o_text_valid,
    output logic        o_token_last,
    output logic [19:0] o_start_line,
    output logic [15:0] o_start_column
);

    logic             full, push;
    ltt_pkg::t_group  grp;
    ltt_pkg::t_res    res;

    assign o_ready = !full;

    ltt_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (i_valid && !full),
        .i_byte  (i_text_byte),
        .i_eoi   (i_end_of_input),
        .o_push  (push),
        .o_group (grp)
    );

    ltt_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_group (grp),
        .o_full  (full),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_res   (res)
    );

    assign o_token_kind   = res.kind;
    assign o_text_char    = res.ch;
    assign o_text_valid   = res.valid;
    assign o_token_last   = res.last;
    assign o_start_line   = res.line;
    assign o_start_column = res.column;

endmodule

### sim/tb_liberty_text_tokenizer.sv
module tb_liberty_text_tokenizer;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] b;
        logic       eoi;
    } t_byte_req;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [7:0]  i_text_byte = 8'd0;
    logic        i_end_of_input = 1'b0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [2:0]  o_token_kind;
    logic [7:0]  o_text_char;
    logic        o_text_valid;
    logic        o_token_last;
    logic [19:0] o_start_line;
    logic [15:0] o_start_column;

    liberty_text_tokenizer i_dut (.*);

    always #5 i_clk = ~i_clk;

    t_byte_req      pending_text[$];
    ltt_pkg::t_res  token_queue[$];
    bit             failed = 1'b0;

    // lexer state mirrored for prediction
    ltt_pkg::t_mode                  lx_mode = ltt_pkg::S_IDLE;
    logic [ltt_pkg::LINE_BITS-1:0]   lx_line = ltt_pkg::LINE_BITS'(1);
    logic [ltt_pkg::COLUMN_BITS-1:0] lx_col = ltt_pkg::COLUMN_BITS'(1);
    logic [7:0]                      lx_held = 8'd0;
    logic [7:0]                      lx_sign = 8'd0;
    int                              lx_depth = 0;
    bit                              lx_star = 0;
    logic [19:0]                     tk_line = 20'd0;
    logic [15:0]                     tk_col = 16'd0;

    function automatic bit digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit letter(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic void push_token(logic [2:0] k, logic [7:0] c, logic v, logic l,
                                       logic [19:0] ln, logic [15:0] cl);
        ltt_pkg::t_res r;
        r.kind = k; r.ch = c; r.valid = v; r.last = l; r.line = ln; r.column = cl;
        token_queue.push_back(r);
    endfunction

    function automatic void tok_char(logic [2:0] k, logic [7:0] c);
        push_token(k, c, 1'b1, 1'b0, tk_line, tk_col);
    endfunction

    function automatic void tok_single(logic [7:0] c);
        push_token(ltt_pkg::K_SINGLE, c, 1'b1, 1'b1, tk_line, tk_col);
    endfunction

    function automatic void tok_close(logic [2:0] k);
        push_token(k, 8'd0, 1'b0, 1'b1, tk_line, tk_col);
    endfunction

    // returns 1 when the byte must be scanned again
    function automatic bit number_suffix(logic [7:0] b);
        if (b == ltt_pkg::C_LK || b == ltt_pkg::C_UK) begin
            tok_char(ltt_pkg::K_NUMBER, ltt_pkg::C_LE);
            tok_char(ltt_pkg::K_NUMBER, ltt_pkg::C_THREE);
            tok_close(ltt_pkg::K_NUMBER);
            lx_mode = ltt_pkg::S_IDLE;
            return 0;
        end
        if (b == ltt_pkg::C_LE || b == ltt_pkg::C_UE) begin
            tok_char(ltt_pkg::K_NUMBER, b);
            lx_mode = ltt_pkg::S_ESGN;
            return 0;
        end
        tok_close(ltt_pkg::K_NUMBER);
        lx_mode = ltt_pkg::S_IDLE;
        return 1;
    endfunction

    function automatic void open_token(logic [7:0] b, logic [19:0] ln, logic [15:0] cl);
        if (b == " " || (b >= 8'd9 && b <= 8'd13)) return;
        tk_line = ln;
        tk_col = cl;
        if (b == ltt_pkg::C_BSL) begin lx_held = b; lx_mode = ltt_pkg::S_BSL; end
        else if (b == ltt_pkg::C_SLASH) begin lx_held = b; lx_mode = ltt_pkg::S_SLASH; end
        else if (b == ltt_pkg::C_QUOTE) lx_mode = ltt_pkg::S_STR;
        else if (digit(b)) begin tok_char(ltt_pkg::K_NUMBER, b); lx_mode = ltt_pkg::S_INT; end
        else if (b == ltt_pkg::C_DOT) begin lx_held = b; lx_mode = ltt_pkg::S_DOT; end
        else if (b == ltt_pkg::C_PLUS || b == ltt_pkg::C_MINUS) begin
            lx_sign = b; lx_mode = ltt_pkg::S_SIGN;
        end
        else if (letter(b) || b == ltt_pkg::C_UNDER) begin
            lx_depth = 0; tok_char(ltt_pkg::K_KEYWD, b); lx_mode = ltt_pkg::S_ID;
        end
        else tok_single(b);
    endfunction

    function automatic void scan_text(logic [7:0] b, logic [19:0] ln, logic [15:0] cl);
        bit again = 1;
        while (again) begin
            again = 0;
            case (lx_mode)
                ltt_pkg::S_IDLE: open_token(b, ln, cl);
                ltt_pkg::S_BSL, ltt_pkg::S_SLASH: begin
                    if (lx_mode == ltt_pkg::S_BSL && b == ltt_pkg::C_NL)
                        lx_mode = ltt_pkg::S_IDLE;
                    else if (lx_mode == ltt_pkg::S_SLASH && b == ltt_pkg::C_SLASH)
                        lx_mode = ltt_pkg::S_LCOM;
                    else if (lx_mode == ltt_pkg::S_SLASH && b == ltt_pkg::C_STAR) begin
                        lx_star = 0; lx_mode = ltt_pkg::S_BCOM;
                    end else begin
                        tok_single(lx_held); lx_mode = ltt_pkg::S_IDLE; again = 1;
                    end
                    lx_held = 8'd0;
                end
                ltt_pkg::S_LCOM: if (b == ltt_pkg::C_NL) lx_mode = ltt_pkg::S_IDLE;
                ltt_pkg::S_BCOM: begin
                    if (b == ltt_pkg::C_SLASH && lx_star) lx_mode = ltt_pkg::S_IDLE;
                    lx_star = (b == ltt_pkg::C_STAR);
                end
                ltt_pkg::S_STR: begin
                    if (b == ltt_pkg::C_QUOTE) begin
                        tok_close(ltt_pkg::K_STRING); lx_mode = ltt_pkg::S_IDLE;
                    end
                    else if (b == ltt_pkg::C_BSL) lx_mode = ltt_pkg::S_SESC;
                    else if (b == ltt_pkg::C_NL) begin
                        tok_close(ltt_pkg::K_BADSTR); lx_mode = ltt_pkg::S_HALT;
                    end
                    else tok_char(ltt_pkg::K_STRING, b);
                end
                ltt_pkg::S_SESC: begin
                    if (b != ltt_pkg::C_NL) tok_char(ltt_pkg::K_STRING, b);
                    lx_mode = ltt_pkg::S_STR;
                end
                ltt_pkg::S_DOT: begin
                    lx_held = 8'd0;
                    if (digit(b)) begin
                        tok_char(ltt_pkg::K_NUMBER, ltt_pkg::C_DOT);
                        tok_char(ltt_pkg::K_NUMBER, b);
                        lx_mode = ltt_pkg::S_FRAC;
                    end else begin
                        tok_single(ltt_pkg::C_DOT); lx_mode = ltt_pkg::S_IDLE; again = 1;
                    end
                end
                ltt_pkg::S_SIGN: begin
                    if (digit(b)) begin
                        tok_char(ltt_pkg::K_NUMBER, lx_sign); tok_char(ltt_pkg::K_NUMBER, b);
                        lx_mode = ltt_pkg::S_INT; lx_sign = 8'd0;
                    end else if (b == ltt_pkg::C_DOT || b == ltt_pkg::C_UNDER)
                        lx_mode = ltt_pkg::S_SDOT;
                    else begin
                        tok_single(lx_sign); lx_sign = 8'd0;
                        lx_mode = ltt_pkg::S_IDLE; again = 1;
                    end
                end
                ltt_pkg::S_SDOT: begin
                    if (digit(b)) begin
                        tok_char(ltt_pkg::K_NUMBER, lx_sign);
                        tok_char(ltt_pkg::K_NUMBER, ltt_pkg::C_DOT);
                        tok_char(ltt_pkg::K_NUMBER, b); lx_mode = ltt_pkg::S_FRAC;
                    end else if (b == ltt_pkg::C_LK || b == ltt_pkg::C_UK ||
                                 b == ltt_pkg::C_LE || b == ltt_pkg::C_UE) begin
                        tok_char(ltt_pkg::K_NUMBER, lx_sign);
                        tok_char(ltt_pkg::K_NUMBER, ltt_pkg::C_DOT);
                        again = number_suffix(b);
                    end else begin
                        tok_single(lx_sign); lx_mode = ltt_pkg::S_IDLE; again = 1;
                    end
                    lx_sign = 8'd0;
                end
                ltt_pkg::S_INT: begin
                    if (digit(b)) tok_char(ltt_pkg::K_NUMBER, b);
                    else if (b == ltt_pkg::C_DOT || b == ltt_pkg::C_UNDER) begin
                        tok_char(ltt_pkg::K_NUMBER, ltt_pkg::C_DOT);
                        lx_mode = ltt_pkg::S_FRAC;
                    end else again = number_suffix(b);
                end
                ltt_pkg::S_FRAC: begin
                    if (digit(b)) tok_char(ltt_pkg::K_NUMBER, b);
                    else again = number_suffix(b);
                end
                ltt_pkg::S_ESGN: begin
                    if (b == ltt_pkg::C_PLUS || b == ltt_pkg::C_MINUS || digit(b)) begin
                        tok_char(ltt_pkg::K_NUMBER, b); lx_mode = ltt_pkg::S_EXP;
                    end else begin
                        tok_close(ltt_pkg::K_NUMBER); lx_mode = ltt_pkg::S_IDLE; again = 1;
                    end
                end
                ltt_pkg::S_EXP: begin
                    if (digit(b)) tok_char(ltt_pkg::K_NUMBER, b);
                    else begin
                        tok_close(ltt_pkg::K_NUMBER); lx_mode = ltt_pkg::S_IDLE; again = 1;
                    end
                end
                ltt_pkg::S_ID: begin
                    if (b == ltt_pkg::C_LBR) begin
                        if (lx_depth < ltt_pkg::BRACKET_MAX) lx_depth++;
                        tok_char(ltt_pkg::K_KEYWD, b);
                    end else if (b == ltt_pkg::C_RBR) begin
                        if (lx_depth > 0) lx_depth--;
                        tok_char(ltt_pkg::K_KEYWD, b);
                    end else if (letter(b) || digit(b) || b == ltt_pkg::C_UNDER ||
                                 b == ltt_pkg::C_DOT || b == ltt_pkg::C_MINUS ||
                                 (b == ltt_pkg::C_COLON && lx_depth > 0))
                        tok_char(ltt_pkg::K_KEYWD, b);
                    else begin
                        tok_close(ltt_pkg::K_KEYWD); lx_mode = ltt_pkg::S_IDLE; again = 1;
                    end
                end
                default: ;
            endcase
        end
    endfunction

    function automatic void predict_tokens(logic [7:0] b, logic eoi);
        logic [19:0] ln;
        logic [15:0] cl;
        if (lx_mode == ltt_pkg::S_HALT) return;
        if (eoi) begin
            case (lx_mode)
                ltt_pkg::S_BSL, ltt_pkg::S_SLASH, ltt_pkg::S_DOT: tok_single(lx_held);
                ltt_pkg::S_SIGN, ltt_pkg::S_SDOT: tok_single(lx_sign);
                ltt_pkg::S_INT, ltt_pkg::S_FRAC, ltt_pkg::S_ESGN, ltt_pkg::S_EXP:
                    tok_close(ltt_pkg::K_NUMBER);
                ltt_pkg::S_ID: tok_close(ltt_pkg::K_KEYWD);
                ltt_pkg::S_STR, ltt_pkg::S_SESC: tok_close(ltt_pkg::K_BADSTR);
                ltt_pkg::S_BCOM: tok_close(ltt_pkg::K_OPENC);
                default: ;
            endcase
            if (lx_mode != ltt_pkg::S_STR && lx_mode != ltt_pkg::S_SESC &&
                lx_mode != ltt_pkg::S_BCOM)
                push_token(ltt_pkg::K_END, 8'd0, 1'b0, 1'b1, 20'd0, 16'd0);
            lx_mode = ltt_pkg::S_HALT;
            return;
        end
        ln = lx_line;
        cl = lx_col;
        if (b == ltt_pkg::C_NL) begin
            if (lx_line != '1) lx_line++;
            lx_col = ltt_pkg::COLUMN_BITS'(1);
        end else if (lx_col != '1) lx_col++;
        scan_text(b, ln, cl);
    endfunction

    // ---------------- stimulus building ----------------
    function automatic void add_byte(logic [7:0] b);
        t_byte_req r;
        r.b = b; r.eoi = 1'b0;
        pending_text.push_back(r);
    endfunction

    function automatic void add_text(string s);
        for (int i = 0; i < s.len(); i++) add_byte(s[i]);
    endfunction

    function automatic logic [7:0] pick(string s);
        return s[$urandom_range(0, s.len() - 1)];
    endfunction

    // noise never opens a string or a block comment, so the stream cannot halt early
    function automatic logic [7:0] noise_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255));
        while (b == ltt_pkg::C_QUOTE || b == ltt_pkg::C_STAR || b == ltt_pkg::C_NL);
        return b;
    endfunction

    function automatic void add_fragment();
        int n;
        logic [7:0] b;
        case ($urandom_range(0, 11))
            0, 1: begin
                add_byte(pick("abcxyzABZ_"));
                n = $urandom_range(0, 8);
                repeat (n) add_byte(pick("az09_.-[]:[]"));
            end
            2, 3: begin
                if ($urandom_range(0, 2) == 0) add_byte(pick("+-"));
                n = $urandom_range(0, 3);
                repeat (n) add_byte(pick("0123456789"));
                if ($urandom_range(0, 1)) add_byte(pick("._"));
                n = $urandom_range(0, 3);
                repeat (n) add_byte(pick("0123456789"));
                case ($urandom_range(0, 3))
                    0: add_byte(pick("kK"));
                    1: begin
                        add_byte(pick("eE"));
                        if ($urandom_range(0, 1)) add_byte(pick("+-"));
                        n = $urandom_range(0, 2);
                        repeat (n) add_byte(pick("0123456789"));
                    end
                    default: ;
                endcase
            end
            4: begin
                add_byte(ltt_pkg::C_QUOTE);
                n = $urandom_range(0, 6);
                repeat (n) begin
                    if ($urandom_range(0, 4) == 0) begin
                        add_byte(ltt_pkg::C_BSL);
                        do b = 8'($urandom_range(0, 255)); while (b == ltt_pkg::C_NL);
                        add_byte(b);
                    end else begin
                        do b = 8'($urandom_range(0, 255));
                        while (b == ltt_pkg::C_QUOTE || b == ltt_pkg::C_BSL ||
                               b == ltt_pkg::C_NL);
                        add_byte(b);
                    end
                end
                add_byte(ltt_pkg::C_QUOTE);
            end
            5: begin
                add_text("//");
                n = $urandom_range(0, 5);
                repeat (n) add_byte(noise_byte());
                add_byte(ltt_pkg::C_NL);
            end
            6: begin
                add_text("/*");
                n = $urandom_range(0, 5);
                repeat (n) add_byte(noise_byte());
                add_text("*/");
            end
            7: add_byte(pick("(){};,=:]"));
            8: add_byte(pick(" \t\n\r\n"));
            9: add_byte(noise_byte());
            10: add_byte(pick("\\./+-"));
            default: begin
                add_byte(pick("+-"));
                add_byte(pick("._"));
                add_byte(pick("xkKeE0 "));
            end
        endcase
        add_byte(pick("  \n;(,"));
    endfunction

    // ---------------- sender ----------------
    int send_gap = 0;
    t_byte_req next_req;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (i_valid && o_ready) begin
                predict_tokens(i_text_byte, i_end_of_input);
                void'(pending_text.pop_front());
            end
            if (!(i_valid && !o_ready)) begin
                if (send_gap > 0) begin
                    i_valid <= 1'b0;
                    send_gap--;
                end else if (pending_text.size() == 0) begin
                    i_valid <= 1'b0;
                end else if (pending_text.size() > 40 && $urandom_range(0, 7) == 0) begin
                    i_valid <= 1'b0;
                    send_gap = $urandom_range(0, 17);
                end else begin
                    next_req = pending_text[0];
                    i_valid <= 1'b1;
                    i_text_byte <= next_req.b;
                    i_end_of_input <= next_req.eoi;
                end
            end
        end
    end

    // ---------------- receiver and checker ----------------
    int tokens_seen = 0;
    int recv_gap = 0;
    int hold_cycles = 0;
    bit hold_done = 0;
    ltt_pkg::t_res want;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                tokens_seen++;
                if (token_queue.size() == 0) begin
                    $error("unexpected token result: kind %0d char %02h", o_token_kind,
                           o_text_char);
                    failed = 1'b1;
                end else begin
                    want = token_queue.pop_front();
                    if (o_token_kind !== want.kind) begin
                        $error("token_kind: expected %0d, got %0d", want.kind, o_token_kind);
                        failed = 1'b1;
                    end
                    if (o_text_char !== want.ch) begin
                        $error("text_char: expected %02h, got %02h", want.ch, o_text_char);
                        failed = 1'b1;
                    end
                    if (o_text_valid !== want.valid) begin
                        $error("text_valid: expected %0d, got %0d", want.valid, o_text_valid);
                        failed = 1'b1;
                    end
                    if (o_token_last !== want.last) begin
                        $error("token_last: expected %0d, got %0d", want.last, o_token_last);
                        failed = 1'b1;
                    end
                    if (o_start_line !== want.line) begin
                        $error("start_line: expected %0d, got %0d", want.line, o_start_line);
                        failed = 1'b1;
                    end
                    if (o_start_column !== want.column) begin
                        $error("start_column: expected %0d, got %0d", want.column,
                               o_start_column);
                        failed = 1'b1;
                    end
                end
            end
            // hold off once for a long stretch so the result queue fills and input stalls
            if (!hold_done && tokens_seen >= 100) begin
                hold_done = 1;
                hold_cycles = 400;
            end
            if (hold_cycles > 0) begin
                i_ready <= 1'b0;
                hold_cycles--;
            end else if (recv_gap > 0) begin
                i_ready <= 1'b0;
                recv_gap--;
            end else if (pending_text.size() > 40 && $urandom_range(0, 7) == 0) begin
                i_ready <= 1'b0;
                recv_gap = $urandom_range(0, 17);
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // ---------------- watchdog ----------------
    int quiet_cycles = 0;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready)) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= 3000) begin
                $display("liberty_text_tokenizer test failed");
                $finish;
            end
        end
    end

    // ---------------- sequence ----------------
    t_byte_req end_req;

    initial begin
        // directed: brackets and ranges, signs, point, suffixes, escapes, comments
        add_text("pin[3:0]] b] ");
        add_text("a[[[[[[[[[[[[[[[[[:]]]]]]]]]]]]]]]]]] ");
        add_text("+1_5k -.e +_x 3.25e-7 1E+5 4K .5 . + -3 ");
        add_text("\"ab\\\"c\\\n\" // note\n/* * / **/ \\\n \\x ");
        add_text("(;){,}");
        add_byte(8'h00);
        add_byte(8'hff);
        add_text("\t7.x\n");
        add_text("q/\n");
        while (pending_text.size() < 372) add_fragment();
        end_req.b = 8'($urandom_range(0, 255));
        end_req.eoi = 1'b1;
        pending_text.push_back(end_req);
        // after the end mark the block is halted and must stay silent
        add_text("z1");
        pending_text.push_back(end_req);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (pending_text.size() != 0 || token_queue.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
        if (!failed && token_queue.size() == 0)
            $display("liberty_text_tokenizer test passed");
        else
            $display("liberty_text_tokenizer test failed");
        $finish;
    end

endmodule

### liberty_text_tokenizer.f
src/ltt_pkg.sv
src/ltt_front.sv
src/ltt_back.sv
src/liberty_text_tokenizer.sv
sim/tb_liberty_text_tokenizer.sv
